// ===== src/iqp_pkg.sv =====
// Package for the IQ-to-polar converter: word types, fixed-point constants
// and the elaboration-time arctangent table. Used by every other file.
package iqp_pkg;

  localparam int SAMPLE_W    = 8;
  localparam int MAG_W       = 16;
  localparam int ANGLE_W     = 16;
  localparam int CORDIC_STEPS = 58;
  localparam int SQRT_STEPS  = 16;
  localparam int VEC_SHIFT   = 53;
  localparam int XY_W        = 63;   // vector components, signed
  localparam int Z_W         = 62;   // angle accumulator, Q60
  localparam int RAD_W       = 32;   // radicand and partial root
  localparam int ROUND_SHIFT = 47;   // Q60 down to Q13

  localparam logic [Z_W-1:0] PI_Q60      = 62'h3243F6A8885A308D;
  localparam logic [Z_W-1:0] HALF_PI_Q60 = 62'h1921FB54442D1847;
  localparam logic [63:0]    QUARTER_PI_Q60 = 64'h0C90FDAA22168C23;

  // angle source selected after the cell row
  localparam logic [1:0] ANG_CORDIC  = 2'd0;
  localparam logic [1:0] ANG_ZERO    = 2'd1;
  localparam logic [1:0] ANG_HALF_PI = 2'd2;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    logic [RAD_W-1:0]       rem;
    logic [RAD_W-1:0]       root;
    logic [1:0]             ang_sel;
    logic                   neg_real;
    logic                   neg_imag;
  } cell_word_t;

  typedef struct packed {
    logic [Z_W-1:0]   ang_mag;
    logic [MAG_W-1:0] magnitude;
    logic             neg_imag;
  } fold_word_t;

  // floor(2^sh / d) by long division, evaluated at elaboration only
  function automatic logic [63:0] pow2_quot(input int sh, input int d);
    logic [63:0] q;
    logic [63:0] rem;
    q   = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], (b == sh)};
      if (rem >= 64'(d)) begin
        rem  = rem - 64'(d);
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(2^-idx) in Q60: truncated terms of the alternating series
  function automatic logic [63:0] atan_q60(input int idx);
    logic [63:0] acc;
    int          sh;
    acc = '0;
    if (idx == 0) begin
      acc = QUARTER_PI_Q60;
    end else begin
      for (int k = 0; k < 30; k++) begin
        sh = 60 - idx * (2 * k + 1);
        if (sh >= 0) begin
          if (k % 2 == 1) acc = acc - pow2_quot(sh, 2 * k + 1);
          else            acc = acc + pow2_quot(sh, 2 * k + 1);
        end
      end
    end
    return acc;
  endfunction

endpackage

// ===== src/iqp_in_if.sv =====
// Input channel: one complex sample per word, valid/ready handshake.
// Depends on iqp_pkg.
interface iqp_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [iqp_pkg::SAMPLE_W-1:0]    sample_imag;
  logic signed [iqp_pkg::SAMPLE_W-1:0]    sample_real;

  modport source (output valid, output sample_imag, output sample_real, input ready);
  modport sink   (input valid, input sample_imag, input sample_real, output ready);
endinterface

// ===== src/iqp_out_if.sv =====
// Result channel: magnitude and phase per word, valid/ready handshake.
// Depends on iqp_pkg.
interface iqp_out_if;
  logic                                  valid;
  logic                                  ready;
  logic [iqp_pkg::MAG_W-1:0]             magnitude;
  logic signed [iqp_pkg::ANGLE_W-1:0]    angle;

  modport source (output valid, output magnitude, output angle, input ready);
  modport sink   (input valid, input magnitude, input angle, output ready);
endinterface

// ===== src/iq_to_polar_converter.sv =====
// Top level of the IQ-to-polar converter: entry stage, CORDIC cell row,
// exit stage and output skid buffer. Depends on iqp_pkg and both channels.
//
// Usage:
//   in_chan carries one complex sample per word (sample_imag, sample_real,
//   signed 8 bit). out_chan returns one word per sample: magnitude as
//   unsigned Q8.8 and angle as signed Q2.13 radians, in input order.
//   A word passes one entry stage, 58 CORDIC cells (one rotation each,
//   the first 16 also resolving one square-root digit), one fold stage
//   and the output register. Throughput is one word per clock while the
//   skid register is empty; every cell hands its word to its neighbor
//   while enabled, so the 58-cell row sets the latency. The row advances
//   on one common enable that only drops while the skid register holds a
//   word. When the receiver stalls, the output holds, the next word lands
//   in the skid register and in_chan.ready falls as it lands; ready comes
//   straight from a flip-flop. Synchronous reset clears every valid bit,
//   so the block comes up empty and ready.
module iq_to_polar_converter (
  input  logic       clk,
  input  logic       rst_n,
  iqp_in_if.sink     in_chan,
  iqp_out_if.source  out_chan
);
  import iqp_pkg::*;

  // cell row links: index 0 is the entry stage output
  logic       chain_v [0:CORDIC_STEPS];
  cell_word_t chain_w [0:CORDIC_STEPS];

  logic              en;
  logic              fold_v;
  fold_word_t        fold_w;

  logic              out_valid_r, out_valid_nxt;
  logic              spare_valid_r, spare_valid_nxt;
  logic [MAG_W-1:0]  out_mag_r, spare_mag_r, w_mag;
  logic [ANGLE_W-1:0] out_ang_r, spare_ang_r, w_ang;
  logic [Z_W:0]      ang_sum;
  logic [ANGLE_W-1:0] ang_q;
  logic              take_out;
  logic              w_valid;

  // the whole row moves while the skid register is empty
  assign en            = !spare_valid_r;
  assign in_chan.ready = en;

  iqp_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_valid    (in_chan.valid),
    .sample_imag (in_chan.sample_imag),
    .sample_real (in_chan.sample_real),
    .valid_out   (chain_v[0]),
    .word_out    (chain_w[0])
  );

  generate
    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
      iqp_cell #(.STEP(g)) u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (chain_v[g]),
        .word_in   (chain_w[g]),
        .valid_out (chain_v[g+1]),
        .word_out  (chain_w[g+1])
      );
    end
  endgenerate

  iqp_fold u_fold (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .valid_in  (chain_v[CORDIC_STEPS]),
    .word_in   (chain_w[CORDIC_STEPS]),
    .valid_out (fold_v),
    .word_out  (fold_w)
  );

  // round the folded angle to Q13 (ties away from zero), then apply sign
  assign ang_sum = {1'b0, fold_w.ang_mag} + ((Z_W+1)'(1) << (ROUND_SHIFT - 1));
  assign ang_q   = ang_sum[ROUND_SHIFT +: ANGLE_W];
  assign w_ang   = fold_w.neg_imag ? (~ang_q + 1'b1) : ang_q;
  assign w_mag   = fold_w.magnitude;
  assign w_valid = fold_v && en;

  // output register frees up when empty or being taken
  assign take_out = !out_valid_r || out_chan.ready;

  always_comb begin
    out_valid_nxt   = out_valid_r;
    spare_valid_nxt = spare_valid_r;
    if (take_out) begin
      if (spare_valid_r) begin
        out_valid_nxt   = 1'b1;
        spare_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = w_valid;
      end
    end else if (w_valid) begin
      spare_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r   <= 1'b0;
      spare_valid_r <= 1'b0;
    end else begin
      out_valid_r   <= out_valid_nxt;
      spare_valid_r <= spare_valid_nxt;
    end
  end

  // payload: drain the skid word first, else load the fresh word
  always_ff @(posedge clk) begin
    if (take_out) begin
      if (spare_valid_r) begin
        out_mag_r <= spare_mag_r;
        out_ang_r <= spare_ang_r;
      end else begin
        out_mag_r <= w_mag;
        out_ang_r <= w_ang;
      end
    end
    if (!take_out && w_valid) begin
      spare_mag_r <= w_mag;
      spare_ang_r <= w_ang;
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.magnitude = out_mag_r;
  assign out_chan.angle     = out_ang_r;
endmodule

// ===== src/iqp_front.sv =====
// Entry stage: folds the sample into the first quadrant, forms the radicand
// and seeds the cell row. Depends on iqp_pkg.
module iqp_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 en,
  input  logic                                 in_valid,
  input  logic signed [iqp_pkg::SAMPLE_W-1:0]  sample_imag,
  input  logic signed [iqp_pkg::SAMPLE_W-1:0]  sample_real,
  output logic                                 valid_out,
  output iqp_pkg::cell_word_t                  word_out
);
  import iqp_pkg::*;

  logic [SAMPLE_W-1:0]   ux, uy;
  logic [2*SAMPLE_W-1:0] sq_sum;
  logic                  valid_r;
  cell_word_t            word_r, word_nxt;

  // magnitude of -128 is 128, still fits unsigned 8 bits
  assign ux = sample_real[SAMPLE_W-1] ? (~sample_real + 1'b1) : sample_real;
  assign uy = sample_imag[SAMPLE_W-1] ? (~sample_imag + 1'b1) : sample_imag;
  assign sq_sum = (2*SAMPLE_W)'(ux) * (2*SAMPLE_W)'(ux)
                + (2*SAMPLE_W)'(uy) * (2*SAMPLE_W)'(uy);

  always_comb begin
    word_nxt.x        = XY_W'(ux) << VEC_SHIFT;
    word_nxt.y        = XY_W'(uy) << VEC_SHIFT;
    word_nxt.z        = '0;
    word_nxt.rem      = RAD_W'(sq_sum) << 16;
    word_nxt.root     = '0;
    word_nxt.neg_real = sample_real[SAMPLE_W-1];
    word_nxt.neg_imag = sample_imag[SAMPLE_W-1];
    if (uy == '0) begin
      word_nxt.ang_sel = ANG_ZERO;
    end else if (ux == '0) begin
      word_nxt.ang_sel = ANG_HALF_PI;
    end else begin
      word_nxt.ang_sel = ANG_CORDIC;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      word_r <= word_nxt;
    end
  end

  assign valid_out = valid_r;
  assign word_out  = word_r;
endmodule

// ===== src/iqp_cell.sv =====
// One cell of the row: a single vectoring CORDIC rotation and, in the first
// cells, one digit of the square root. Depends on iqp_pkg.
module iqp_cell #(
  parameter int STEP = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 valid_in,
  input  iqp_pkg::cell_word_t  word_in,
  output logic                 valid_out,
  output iqp_pkg::cell_word_t  word_out
);
  import iqp_pkg::*;

  localparam logic [63:0]     ATAN_FULL = atan_q60(STEP);
  localparam logic [Z_W-1:0]  ATAN      = ATAN_FULL[Z_W-1:0];
  localparam logic [XY_W-1:0] LOW_MASK  = (XY_W'(1) << STEP) - XY_W'(1);

  logic                   valid_r;
  cell_word_t             word_r, word_nxt;
  logic [XY_W-1:0]        dx, dy;
  logic                   y_pos;
  logic [RAD_W-1:0]       rem_nxt, root_nxt;

  // shift toward zero: floor shift, plus one for a negative with bits lost
  assign dx = XY_W'(word_in.y >>> STEP)
            + XY_W'(word_in.y[XY_W-1] && (|(word_in.y & LOW_MASK)));
  assign dy = XY_W'(word_in.x >>> STEP)
            + XY_W'(word_in.x[XY_W-1] && (|(word_in.x & LOW_MASK)));
  assign y_pos = !word_in.y[XY_W-1] && (|word_in.y);

  generate
    if (STEP < SQRT_STEPS) begin : g_sqrt
      localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (30 - 2 * STEP);
      logic [RAD_W:0] trial;
      assign trial = {1'b0, word_in.root} + {1'b0, BIT};
      always_comb begin
        if ({1'b0, word_in.rem} >= trial) begin
          rem_nxt  = word_in.rem - trial[RAD_W-1:0];
          root_nxt = (word_in.root >> 1) + BIT;
        end else begin
          rem_nxt  = word_in.rem;
          root_nxt = word_in.root >> 1;
        end
      end
    end else begin : g_pass
      assign rem_nxt  = word_in.rem;
      assign root_nxt = word_in.root;
    end
  endgenerate

  always_comb begin
    word_nxt      = word_in;
    word_nxt.rem  = rem_nxt;
    word_nxt.root = root_nxt;
    if (y_pos) begin
      word_nxt.x = word_in.x + dx;
      word_nxt.y = word_in.y - dy;
      word_nxt.z = word_in.z + ATAN;
    end else begin
      word_nxt.x = word_in.x - dx;
      word_nxt.y = word_in.y + dy;
      word_nxt.z = word_in.z - ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      word_r <= word_nxt;
    end
  end

  assign valid_out = valid_r;
  assign word_out  = word_r;
endmodule

// ===== src/iqp_fold.sv =====
// Exit stage: picks the first-quadrant angle, folds it to the half plane and
// rounds the square root. Depends on iqp_pkg.
module iqp_fold (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 valid_in,
  input  iqp_pkg::cell_word_t  word_in,
  output logic                 valid_out,
  output iqp_pkg::fold_word_t  word_out
);
  import iqp_pkg::*;

  logic [Z_W-1:0] z_sel;
  logic           valid_r;
  fold_word_t     word_r, word_nxt;

  always_comb begin
    unique case (word_in.ang_sel)
      ANG_ZERO:    z_sel = '0;
      ANG_HALF_PI: z_sel = HALF_PI_Q60;
      ANG_CORDIC:  z_sel = word_in.z;
      default:     z_sel = word_in.z;
    endcase
  end

  always_comb begin
    word_nxt.ang_mag   = word_in.neg_real ? (PI_Q60 - z_sel) : z_sel;
    // round up when the remainder exceeds the root
    word_nxt.magnitude = MAG_W'(word_in.root) + MAG_W'(word_in.rem > word_in.root);
    word_nxt.neg_imag  = word_in.neg_imag;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      word_r <= word_nxt;
    end
  end

  assign valid_out = valid_r;
  assign word_out  = word_r;
endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for iq_to_polar_converter: a scoreboard class predicts
// magnitude and phase for every accepted sample word and checks each result word.
// Depends on iqp_pkg, iqp_in_if and iqp_out_if from the RTL.
module tb;

  localparam int LATENCY      = 60;   // accepting edge to out_chan.valid
  localparam int DRAIN_CYCLES = LATENCY + 20;
  localparam int STALL_LIMIT  = 2000; // cycles with no handshake at all
  localparam int HOLD_CYCLES  = 400;  // long receiver hold-off
  localparam int PHASE_ITEMS  = 320;
  localparam int FLOOD_ITEMS  = 150;
  localparam int MAX_REPORTS  = 200;

  typedef logic signed [iqp_pkg::SAMPLE_W-1:0] sample_t;

  typedef struct {
    logic [iqp_pkg::MAG_W-1:0]          magnitude;
    logic signed [iqp_pkg::ANGLE_W-1:0] angle;
  } polar_t;

  // Predict magnitude and phase of each sample word, hold the predictions in
  // input order and compare result words against the oldest one.
  class polar_scoreboard;
    longint atan_table[iqp_pkg::CORDIC_STEPS];
    polar_t expected_q[$];
    int     mismatches;
    int     checked;

    function new();
      longint acc;
      int     sh;
      mismatches = 0;
      checked    = 0;
      atan_table[0] = longint'(iqp_pkg::QUARTER_PI_Q60);
      // atan(2^-i) in Q60: truncated terms of the alternating series
      for (int i = 1; i < iqp_pkg::CORDIC_STEPS; i++) begin
        acc = 0;
        for (int k = 0; 60 - i * (2 * k + 1) >= 0; k++) begin
          sh = 60 - i * (2 * k + 1);
          if (k % 2 == 1) acc = acc - (longint'(1) << sh) / (2 * k + 1);
          else            acc = acc + (longint'(1) << sh) / (2 * k + 1);
        end
        atan_table[i] = acc;
      end
    endfunction

    // shift right, truncating toward zero
    function longint shift_toward_zero(longint v, int s);
      if (v >= 0) return v >> s;
      return -((-v) >> s);
    endfunction

    function void note_sample(sample_t im, sample_t re);
      longint          ux, uy, x, y, z, dx, dy, q;
      longint unsigned rad, root, bitv;
      polar_t          want;
      ux = (re < 0) ? -longint'(re) : longint'(re);
      uy = (im < 0) ? -longint'(im) : longint'(im);

      // magnitude: rounded integer root of 65536 * (I*I + R*R)
      rad  = longint'(ux * ux + uy * uy) << 16;
      root = 0;
      bitv = longint'(1) << 32;
      while (bitv > rad) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (rad >= root + bitv) begin
          rad  = rad - (root + bitv);
          root = (root >> 1) + bitv;
        end else begin
          root = root >> 1;
        end
        bitv = bitv >> 2;
      end
      if (rad > root) root = root + 1;
      want.magnitude = root[iqp_pkg::MAG_W-1:0];

      // phase: axes exact, otherwise vectoring CORDIC in the first quadrant
      if (uy == 0) begin
        z = 0;
      end else if (ux == 0) begin
        z = longint'(iqp_pkg::HALF_PI_Q60);
      end else begin
        x = ux << iqp_pkg::VEC_SHIFT;
        y = uy << iqp_pkg::VEC_SHIFT;
        z = 0;
        for (int i = 0; i < iqp_pkg::CORDIC_STEPS; i++) begin
          dx = shift_toward_zero(y, i);
          dy = shift_toward_zero(x, i);
          if (y > 0) begin
            x = x + dx;
            y = y - dy;
            z = z + atan_table[i];
          end else begin
            x = x - dx;
            y = y + dy;
            z = z - atan_table[i];
          end
        end
      end
      // fold back to the sample's quadrant; the negative real axis gives +pi
      if (re < 0 && !(ux == 0 && uy == 0)) z = longint'(iqp_pkg::PI_Q60) - z;
      if (im < 0) z = -z;
      // round Q60 to Q13, ties away from zero
      if (z >= 0)
        q = (z + (longint'(1) << (iqp_pkg::ROUND_SHIFT - 1))) >> iqp_pkg::ROUND_SHIFT;
      else
        q = -(((-z) + (longint'(1) << (iqp_pkg::ROUND_SHIFT - 1))) >> iqp_pkg::ROUND_SHIFT);
      want.angle = q[iqp_pkg::ANGLE_W-1:0];
      expected_q.push_back(want);
    endfunction

    function void check_result(logic [iqp_pkg::MAG_W-1:0] mag,
                               logic signed [iqp_pkg::ANGLE_W-1:0] ang);
      polar_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected result word: magnitude %0d angle %0d",
                   $time, mag, ang);
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (mag !== want.magnitude) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: magnitude mismatch: expected %0d, actual %0d",
                   $time, want.magnitude, mag);
      end
      if (ang !== want.angle) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: angle mismatch: expected %0d, actual %0d",
                   $time, want.angle, ang);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic hold_req;
  int   tx_idle_pct;
  int   rx_stall_pct;
  int   hold_left;
  int   stall_cycles;
  int   phases_run;

  polar_scoreboard sb;

  iqp_in_if  in_chan ();
  iqp_out_if out_chan ();

  iq_to_polar_converter DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // Directed words as (imag, real): zero, both axes in both directions with
  // unit and full-scale values, the negative real axis, the four corners,
  // unit diagonals and a few lopsided points near the axes.
  sample_t dir_imag [23] = '{  0,    0,    0,  0,  0,  127, -128,  1, -1,
                              127, -128,  127, -128,  1, -1,  1, -1,
                              1,  127, -128,  -1,  5,  -3};
  sample_t dir_real [23] = '{  0,  127, -128,  1, -1,    0,    0,  0,  0,
                              127, -128, -128,  127,  1, -1, -1,  1,
                              127,   1,   -1, -128, -3,   5};

  // Toggle high and low with a 10-unit period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Sample both channels at the rising edge. Note accepted input words first,
  // then check accepted result words against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_chan.valid && in_chan.ready)
        sb.note_sample(in_chan.sample_imag, in_chan.sample_real);
      if (out_chan.valid && out_chan.ready)
        sb.check_result(out_chan.magnitude, out_chan.angle);
    end
  end

  // Drive the receiver: keep ready low in reset, hold it low for a long
  // stretch on request, otherwise stall at random with the current percentage.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left = 0;
      out_chan.ready <= 1'b0;
    end else begin
      if (hold_req) hold_left = HOLD_CYCLES;
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
      end
    end
  end

  // Count cycles without any handshake; end the run when the limit is hit.
  initial begin : watchdog
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("%0t: watchdog: no handshake for %0d cycles", $time, STALL_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  // Offer one sample word after a random idle gap and hold it until accepted.
  // Leave valid high afterwards so back-to-back words need no extra edge.
  task automatic send_sample(sample_t im, sample_t re);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid       <= 1'b1;
    in_chan.sample_imag <= im;
    in_chan.sample_real <= re;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
  endtask

  // Drop valid and wait until every predicted word has come back.
  task automatic drain();
    in_chan.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Pick a random sample: mostly uniform, with extra weight on the axes,
  // full-scale corners and diagonals where the phase folds.
  task automatic random_sample(output sample_t im, output sample_t re);
    int      pick;
    sample_t edges [5];
    edges = '{-128, -1, 0, 1, 127};
    pick  = $urandom_range(0, 99);
    im    = sample_t'($urandom());
    re    = sample_t'($urandom());
    if (pick >= 94) begin
      im = ($urandom_range(0, 1) == 1) ? -re : re;
    end else if (pick >= 88) begin
      im = edges[$urandom_range(0, 4)];
      re = edges[$urandom_range(0, 4)];
    end else if (pick >= 80) begin
      re = 0;
    end else if (pick >= 70) begin
      im = 0;
    end
  endtask

  // Run one block of random words with the given idle and stall rates.
  task automatic run_phase(int count, int tx_pct, int rx_pct);
    sample_t im, re;
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    for (int n = 0; n < count; n++) begin
      random_sample(im, re);
      send_sample(im, re);
    end
    drain();
    phases_run++;
  endtask

  initial begin
    sb           = new();
    rst_n        = 1'b0;
    hold_req     = 1'b0;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    phases_run   = 0;
    in_chan.valid       = 1'b0;
    in_chan.sample_imag = '0;
    in_chan.sample_real = '0;

    // Hold reset once, then release it.
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words, light idling on both sides.
    tx_idle_pct  = 18;
    rx_stall_pct = 18;
    foreach (dir_imag[i]) send_sample(dir_imag[i], dir_real[i]);
    drain();

    // Random phases: no idling, sender idle, receiver stalling, both.
    run_phase(PHASE_ITEMS, 0, 0);
    run_phase(PHASE_ITEMS, 66, 0);
    run_phase(PHASE_ITEMS, 0, 66);
    run_phase(PHASE_ITEMS, 18, 18);

    // Flood: hold the receiver off while the sender offers words back to
    // back, so the row fills up and in_chan.ready drops. The drain at the
    // end of the phase pauses the sender until every word is back.
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    run_phase(FLOOD_ITEMS, 0, 0);

    // Let the row settle, then catch any word that never came back.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending() != 0) begin
      $display("%0t: %0d predicted words never came back", $time, sb.pending());
      sb.mismatches += sb.pending();
    end

    $display("Checked %0d result words over directed corners and %0d random phases,",
             sb.checked, phases_run);
    $display("including idle sender, stalled receiver and a full-row back-pressure stretch.");
    if (sb.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/iqp_pkg.sv
src/iqp_in_if.sv
src/iqp_out_if.sv
src/iqp_front.sv
src/iqp_cell.sv
src/iqp_fold.sv
src/iq_to_polar_converter.sv
verif/tb.sv
